// ===== design/dpf_pkg.sv =====
// Package for the duplicate-dropping packet buffer.
// Holds command codes, fixed field widths and the controller/datapath handshake types.
// No dependencies.
`default_nettype none

package dpf_pkg;

	localparam int LIMIT_W = 7;
	localparam int COUNT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_FWD = 2'd1;
	localparam logic [1:0] CMD_CNT = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dpf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dpf_stat_t;

endpackage

`default_nettype wire

// ===== design/dpf_in_if.sv =====
// Input channel of the packet buffer: valid/ready handshake with one command transaction.
// ID and time field widths follow the parameters; no other dependencies.
`default_nettype none

interface dpf_in_if #(
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic [ID_BITS-1:0]   source;
	logic [ID_BITS-1:0]   destination;
	logic [TIME_BITS-1:0] timestamp;
	logic [TIME_BITS-1:0] start_time;
	logic [TIME_BITS-1:0] end_time;

	modport src (
		output valid, command, source, destination, timestamp, start_time, end_time,
		input  ready
	);
	modport snk (
		input  valid, command, source, destination, timestamp, start_time, end_time,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/dpf_out_if.sv =====
// Result channel of the packet buffer: valid/ready handshake with one result transaction.
// ID and time field widths follow the parameters; no other dependencies.
`default_nettype none

interface dpf_out_if #(
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) ();
	logic                 valid;
	logic                 ready;
	logic                 added;
	logic                 has_packet;
	logic [ID_BITS-1:0]   out_source;
	logic [ID_BITS-1:0]   out_destination;
	logic [TIME_BITS-1:0] out_timestamp;
	logic [6:0]           match_count;

	modport src (
		output valid, added, has_packet, out_source, out_destination, out_timestamp,
		       match_count,
		input  ready
	);
	modport snk (
		input  valid, added, has_packet, out_source, out_destination, out_timestamp,
		       match_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/dedup_packet_fifo_with_range_count.sv =====
// Top level of the duplicate-dropping packet buffer with destination/time-window count.
// Depends on dpf_pkg, dpf_in_if, dpf_out_if, dpf_ctrl, dpf_dp and dpf_ram.
//
// Stores up to memory_limit (source, destination, timestamp) packets in a ring in one RAM.
// Each transaction on in_ch yields exactly one result transaction on out_ch. An add or a
// count reads every stored entry through the single RAM read port, one entry per cycle;
// a forward reads only the head entry, and an unknown command or a forward on an empty
// buffer reads none. One transaction is worked on at a time; the next is accepted once
// the result is in the output register, even while that result still waits for
// out_ch.ready. memory_limit is written through cfg_we/cfg_wdata and resets to 64; it is
// to be written only while idle, which the block itself does not enforce. Reset clears
// the pointers at once; there is no clearing pass over the RAM.
`default_nettype none

module dedup_packet_fifo_with_range_count
	import dpf_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	dpf_in_if.snk                   in_ch,
	dpf_out_if.src                  out_ch
);

	dpf_cmd_t  cmd;
	dpf_stat_t stat;

	dpf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dpf_dp #(
		.DEPTH    (DEPTH),
		.ID_BITS  (ID_BITS),
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_command     (in_ch.command),
		.in_source      (in_ch.source),
		.in_destination (in_ch.destination),
		.in_timestamp   (in_ch.timestamp),
		.in_start_time  (in_ch.start_time),
		.in_end_time    (in_ch.end_time),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_added      (out_ch.added),
		.out_has_packet (out_ch.has_packet),
		.out_source     (out_ch.out_source),
		.out_destination(out_ch.out_destination),
		.out_timestamp  (out_ch.out_timestamp),
		.out_match_count(out_ch.match_count)
	);

endmodule

`default_nettype wire

// ===== design/dpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module dpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/dpf_ctrl.sv =====
// Controller of the packet buffer: accept, scan, finish sequencing.
// Depends on dpf_pkg for the command/status types.
`default_nettype none

module dpf_ctrl
	import dpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire dpf_stat_t stat,
	output      dpf_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the result register can take the new result
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready   = ready_q;
	assign cmd.load   = in_valid && ready_q;
	assign cmd.step   = (state_q == ST_SCAN);
	assign cmd.finish = (state_q == ST_FINISH) && stat.out_free;

endmodule

`default_nettype wire

// ===== design/dpf_dp.sv =====
// Datapath of the packet buffer: entry RAM, ring pointers, scan compare and result register.
// Depends on dpf_pkg and dpf_ram.
`default_nettype none

module dpf_dp
	import dpf_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [LIMIT_W-1:0]   cfg_wdata,
	input  wire logic [1:0]           in_command,
	input  wire logic [ID_BITS-1:0]   in_source,
	input  wire logic [ID_BITS-1:0]   in_destination,
	input  wire logic [TIME_BITS-1:0] in_timestamp,
	input  wire logic [TIME_BITS-1:0] in_start_time,
	input  wire logic [TIME_BITS-1:0] in_end_time,
	input  wire dpf_cmd_t             cmd,
	output      dpf_stat_t            stat,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 out_added,
	output      logic                 out_has_packet,
	output      logic [ID_BITS-1:0]   out_source,
	output      logic [ID_BITS-1:0]   out_destination,
	output      logic [TIME_BITS-1:0] out_timestamp,
	output      logic [COUNT_W-1:0]   out_match_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int EW = 2 * ID_BITS + TIME_BITS;
	localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;
	localparam int CW = (OW > COUNT_W) ? OW : COUNT_W;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// control state
	logic [AW-1:0]      head_q, tail_q, rd_ptr_q;
	logic [OW-1:0]      occ_q, rem_q, cnt_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               vld_s1, dup_q, out_valid_q;

	// captured transaction
	logic [1:0]           cmd_q;
	logic [ID_BITS-1:0]   src_q, dst_q;
	logic [TIME_BITS-1:0] ts_q, lo_q, hi_q;
	logic                 win_ok_q;

	// result payload
	logic                 added_q, has_q;
	logic [ID_BITS-1:0]   osrc_q, odst_q;
	logic [TIME_BITS-1:0] ots_q;
	logic [COUNT_W-1:0]   ocnt_q;

	logic                 ram_we, ram_re;
	logic [EW-1:0]        rd_data;
	logic [ID_BITS-1:0]   rd_src, rd_dst;
	logic [TIME_BITS-1:0] rd_ts;
	logic [LW-1:0]        lim_raw, lim_eff;
	logic                 evict, hit_dup, hit_cnt, fwd_hit;
	logic [OW-1:0]        scan_len;
	logic [CW-1:0]        cnt_ext;
	logic [OW:0]          ptr_sum;

	assign rd_src = rd_data[EW-1 -: ID_BITS];
	assign rd_dst = rd_data[TIME_BITS +: ID_BITS];
	assign rd_ts  = rd_data[TIME_BITS-1:0];

	// a limit of zero acts as one, above the depth acts as the depth
	always_comb begin
		lim_raw = LW'(limit_q);
		lim_eff = lim_raw;
		if (lim_raw == '0) begin
			lim_eff = LW'(1);
		end else if (lim_raw > LW'(DEPTH)) begin
			lim_eff = LW'(DEPTH);
		end
	end

	assign evict   = (LW'(occ_q) >= lim_eff) && (occ_q != '0);
	assign hit_dup = (rd_src == src_q) && (rd_dst == dst_q) && (rd_ts == ts_q);
	assign hit_cnt = win_ok_q && (rd_dst == dst_q) && (rd_ts >= lo_q) && (rd_ts <= hi_q);
	assign fwd_hit = (cmd_q == CMD_FWD) && (occ_q != '0);
	assign cnt_ext = CW'(cnt_q);

	always_comb begin
		case (in_command)
			CMD_ADD, CMD_CNT: scan_len = occ_q;
			CMD_FWD:          scan_len = (occ_q != '0) ? OW'(1) : '0;
			default:          scan_len = '0;
		endcase
	end

	assign ram_re = cmd.step && (rem_q != '0);
	assign ram_we = cmd.finish && (cmd_q == CMD_ADD) && !dup_q;

	dpf_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({src_q, dst_q, ts_q}),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			dup_q       <= 1'b0;
			vld_s1      <= 1'b0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rd_ptr_q <= head_q;
				rem_q    <= scan_len;
				cnt_q    <= '0;
				dup_q    <= 1'b0;
			end
			vld_s1 <= ram_re;
			if (ram_re) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				rem_q    <= rem_q - 1'b1;
			end
			if (vld_s1) begin
				if (hit_dup) begin
					dup_q <= 1'b1;
				end
				if (hit_cnt) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				case (cmd_q)
					CMD_ADD: begin
						if (!dup_q) begin
							tail_q <= ptr_inc(tail_q);
							if (evict) begin
								head_q <= ptr_inc(head_q);
							end else begin
								occ_q <= occ_q + 1'b1;
							end
						end
					end
					CMD_FWD: begin
						if (occ_q != '0) begin
							head_q <= ptr_inc(head_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers; fields of other commands read as zero
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= in_command;
			src_q    <= in_source;
			dst_q    <= in_destination;
			ts_q     <= in_timestamp;
			lo_q     <= in_start_time;
			hi_q     <= in_end_time;
			win_ok_q <= (in_end_time >= in_start_time);
		end
		if (cmd.finish) begin
			added_q <= (cmd_q == CMD_ADD) && !dup_q;
			has_q   <= fwd_hit;
			osrc_q  <= fwd_hit ? rd_src : '0;
			odst_q  <= fwd_hit ? rd_dst : '0;
			ots_q   <= fwd_hit ? rd_ts : '0;
			ocnt_q  <= (cmd_q == CMD_CNT) ? cnt_ext[COUNT_W-1:0] : '0;
		end
	end

	assign stat.scan_done = (rem_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_added       = added_q;
	assign out_has_packet  = has_q;
	assign out_source      = osrc_q;
	assign out_destination = odst_q;
	assign out_timestamp   = ots_q;
	assign out_match_count = ocnt_q;

	assign ptr_sum = (OW + 1)'(head_q) + (OW + 1)'(occ_q);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above depth");

	a_tail_ring: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == ((ptr_sum >= (OW + 1)'(DEPTH)) ? AW'(ptr_sum - (OW + 1)'(DEPTH))
		                                         : AW'(ptr_sum)))
		else $error("tail pointer out of step with head and occupancy");

	a_add_stores: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (cmd_q == CMD_ADD) && !dup_q) |=> (occ_q != '0))
		else $error("accepted add left the buffer empty");

endmodule

`default_nettype wire
